// ----- rtl/core/sfd_pkg.sv -----
// Shared constants and pipeline control types for the stereo flanger core.
package sfd_pkg;

  // Default number of stereo frames held in the delay store.
  localparam int DelayDepthDefault = 350;

  // Fixed-point format of the sweep offset and the sweep step.
  localparam int FracBits = 16;
  localparam int FracOne  = 65536;

  // Reset value of the sweep step register (about 0.002 frames per frame).
  localparam logic [15:0] StepReset = 16'd131;

  // Load strobes for the arithmetic stages behind the delay store read.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } sfd_ld_t;

endpackage

// ----- rtl/core/stereo_flanger_swept_delay_core.sv -----
// Top level of the stereo flanger: delay store, sweep state and stream control.
//
//  channel   direction  transaction content
//  s_axis    in         s_tdata = {right_in, left_in}, one stereo frame
//  m_axis    out        m_tdata = {right_out, left_out}, one stereo frame
//  cfg       in         cfg_wdata = sweep_step, taken whenever cfg_we is high
//
// One frame is accepted per cycle when the output side keeps up; each result
// passes the store read, difference, product, blend and output registers. The
// sweep offset and write position update in the cycle of acceptance, and the
// delay store has two read ports and one write port, so both taps and the new
// frame are handled in that cycle. After reset the block accepts at once: a
// fill count marks which store entries were written, and unwritten entries
// read as zero. Stages advance independently, so a result held on the output
// does not block frames behind it until the pipeline is full.
module stereo_flanger_swept_delay_core #(
  parameter int DELAY_DEPTH = sfd_pkg::DelayDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  // Fields from bit 0: left_in[15:0], right_in[31:16].
  input  logic [31:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: left_out[15:0], right_out[31:16].
  output logic [31:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import sfd_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int CW = $clog2(DELAY_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int OW = CW + FracBits + 1;
  localparam logic signed [OW-1:0] OffReset = OW'((DELAY_DEPTH / 2) * FracOne);
  localparam logic signed [OW-1:0] OffMax   = OW'(DELAY_DEPTH * FracOne);

  // Sweep and write state.
  logic [15:0]          sweep_step;
  logic [AW-1:0]        wp;
  logic [AW-1:0]        wp_next;
  logic [CW-1:0]        fill;
  logic signed [OW-1:0] off;
  logic signed [OW-1:0] off_next;
  logic                 falling;
  logic                 flip;

  // Tap addressing.
  logic [CW-1:0]        whole;
  logic [15:0]          frac;
  logic [SW-1:0]        tap_sum;
  logic [AW-1:0]        p1;
  logic [AW-1:0]        p2;

  // Delay store and its registered read side.
  logic [31:0]          store [DELAY_DEPTH];
  logic [31:0]          rd_a;
  logic [31:0]          rd_b;
  logic                 ok_a;
  logic                 ok_b;
  logic [15:0]          frac1;
  logic [31:0]          dry1;
  logic [31:0]          tap_a;
  logic [31:0]          tap_b;

  // Stage occupancy and load strobes.
  logic                 v1, v2, v3, v4, v5;
  logic                 take1, take2, take3, take4, take5;
  logic                 accept;
  sfd_ld_t              ld;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    take5    = !v5 || m_tready;
    take4    = !v4 || take5;
    take3    = !v3 || take4;
    take2    = !v2 || take3;
    take1    = !v1 || take2;
    s_tready = take1 && !rst;
    accept   = s_tvalid && s_tready;
    ld       = '{ld2: take2, ld3: take3, ld4: take4, ld5: take5};
    m_tvalid = v5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (take1) v1 <= s_tvalid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
      if (take4) v4 <= v3;
      if (take5) v5 <= v4;
    end
  end

  // Sweep step register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_step <= StepReset;
    end else if (cfg_we) begin
      sweep_step <= cfg_wdata;
    end
  end

  // Read taps: a negative offset reads at the write position with no blend.
  always_comb begin
    if (off[OW-1]) begin
      whole = '0;
      frac  = '0;
    end else begin
      whole = off[OW-2:FracBits];
      frac  = off[FracBits-1:0];
    end
    tap_sum = SW'(wp) + SW'(whole);
    if (tap_sum >= SW'(2 * DELAY_DEPTH)) begin
      p1 = AW'(tap_sum - SW'(2 * DELAY_DEPTH));
    end else if (tap_sum >= SW'(DELAY_DEPTH)) begin
      p1 = AW'(tap_sum - SW'(DELAY_DEPTH));
    end else begin
      p1 = AW'(tap_sum);
    end
    p2 = (p1 == AW'(DELAY_DEPTH - 1)) ? '0 : p1 + AW'(1);
  end

  // Next sweep state after one frame.
  always_comb begin
    wp_next  = (wp == AW'(DELAY_DEPTH - 1)) ? '0 : wp + AW'(1);
    off_next = falling ? off - $signed({{(OW-16){1'b0}}, sweep_step})
                       : off + $signed({{(OW-16){1'b0}}, sweep_step});
    flip     = off_next[OW-1] || (off_next > OffMax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fill    <= '0;
      off     <= OffReset;
      falling <= 1'b0;
    end else if (accept) begin
      wp      <= wp_next;
      off     <= off_next;
      falling <= falling ^ flip;
      if (fill != CW'(DELAY_DEPTH)) begin
        fill <= fill + CW'(1);
      end
    end
  end

  // Delay store: both taps read the old contents before the new frame lands.
  always_ff @(posedge clk) begin
    if (take1) begin
      rd_a <= store[p1];
      rd_b <= store[p2];
    end
    if (accept) begin
      store[wp] <= s_tdata;
    end
  end

  // Writes fill the store in order from entry zero, so the fill count marks validity.
  always_ff @(posedge clk) begin
    if (take1) begin
      ok_a  <= CW'(p1) < fill;
      ok_b  <= CW'(p2) < fill;
      frac1 <= frac;
      dry1  <= s_tdata;
    end
  end

  assign tap_a = ok_a ? rd_a : '0;
  assign tap_b = ok_b ? rd_b : '0;

  // Per-channel blend pipelines.
  sfd_blend u_left (
    .clk      (clk),
    .ld       (ld),
    .near_tap (tap_a[15:0]),
    .far_tap  (tap_b[15:0]),
    .frac     (frac1),
    .dry      (dry1[15:0]),
    .wet      (m_tdata[15:0])
  );

  sfd_blend u_right (
    .clk      (clk),
    .ld       (ld),
    .near_tap (tap_a[31:16]),
    .far_tap  (tap_b[31:16]),
    .frac     (frac1),
    .dry      (dry1[31:16]),
    .wet      (m_tdata[31:16])
  );

  // Until the store wraps, the write position equals the fill count.
  a_fill_tracks_wp : assert property (@(posedge clk) disable iff (rst)
    (fill != CW'(DELAY_DEPTH)) |-> (CW'(wp) == fill))
    else $error("write position out of step with fill count");

  // Both tap addresses stay inside the store.
  a_taps_in_range : assert property (@(posedge clk) disable iff (rst)
    accept |-> (((AW+1)'(p1) < (AW+1)'(DELAY_DEPTH)) &&
                ((AW+1)'(p2) < (AW+1)'(DELAY_DEPTH))))
    else $error("tap address beyond delay depth");

  // Every accepted frame advances the write position by one, with wrap.
  a_wp_advance : assert property (@(posedge clk) disable iff (rst)
    accept |=> (wp == (($past(wp) == AW'(DELAY_DEPTH - 1)) ? '0 : $past(wp) + AW'(1))))
    else $error("write position did not advance");

endmodule

// ----- rtl/core/sfd_blend.sv -----
// One channel of the interpolate, add and saturate pipeline.
module sfd_blend (
  input  logic               clk,
  input  sfd_pkg::sfd_ld_t   ld,
  input  logic signed [15:0] near_tap,
  input  logic signed [15:0] far_tap,
  input  logic        [15:0] frac,
  input  logic signed [15:0] dry,
  output logic signed [15:0] wet
);
  import sfd_pkg::*;

  logic signed [16:0] diff;
  logic signed [15:0] near2;
  logic        [15:0] frac2;
  logic signed [15:0] dry2;

  logic signed [33:0] prod;
  logic signed [15:0] near3;
  logic signed [15:0] dry3;

  logic signed [33:0] acc;
  logic               round_up;
  logic signed [15:0] blend;
  logic signed [15:0] blend4;
  logic signed [15:0] dry4;

  logic signed [16:0] sum;
  logic signed [15:0] sat;

  // The blend is rewritten as near + frac * (far - near), so one multiply suffices.
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      diff  <= {far_tap[15], far_tap} - {near_tap[15], near_tap};
      near2 <= near_tap;
      frac2 <= frac;
      dry2  <= dry;
    end
  end

  // Unsigned fraction times signed difference.
  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      prod  <= $signed({1'b0, frac2}) * diff;
      near3 <= near2;
      dry3  <= dry2;
    end
  end

  // Scale back by the fraction width, truncating toward zero.
  always_comb begin
    acc      = $signed({{2{near3[15]}}, near3, {FracBits{1'b0}}}) + prod;
    round_up = acc[33] && (|acc[FracBits-1:0]);
    blend    = acc[31:16] + $signed({15'b0, round_up});
  end

  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      blend4 <= blend;
      dry4   <= dry3;
    end
  end

  // Add the dry sample and clamp to the 16-bit range.
  always_comb begin
    sum = {dry4[15], dry4} + {blend4[15], blend4};
    if (sum[16] != sum[15]) begin
      sat = sum[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld5) begin
      wet <= sat;
    end
  end

endmodule

// ----- verif/stereo_flanger_swept_delay_core_tb.sv -----
// Self-checking testbench for the stereo flanger swept delay core.
module stereo_flanger_swept_delay_core_tb;
  import sfd_pkg::*;

  localparam int DEPTH = DelayDepthDefault;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;

  // One stereo frame as it travels on tdata, left channel in the low half.
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } frame_t;

  // One directed row: the frame sent and the frame that must come back.
  typedef struct packed {
    frame_t stim;
    frame_t res;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Predictor state: delay store, write position and sweep.
  logic signed [15:0] dly_left [DEPTH];
  logic signed [15:0] dly_right [DEPTH];
  int                 wr_pos = 0;
  longint             sweep_ofs = longint'(DEPTH / 2) * FracOne;
  bit                 sweep_down = 1'b0;
  logic [15:0]        sweep_step = StepReset;

  frame_t frames_due [$];
  int     faults = 0;
  int     quiet_cycles = 0;
  bit     sender_idle = 1'b1;
  bit     sink_idle = 1'b1;
  bit     hold_request = 1'b0;
  probe_t probes [0:11];

  always #5 clk = ~clk;

  stereo_flanger_swept_delay_core #(
    .DELAY_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),   // left_in[15:0], right_in[31:16]
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),   // left_out[15:0], right_out[31:16]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  function automatic logic signed [15:0] clip16(longint v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7FFF;
    return v[15:0];
  endfunction

  // Linear blend of two taps, truncated toward zero.
  function automatic longint mix_taps(logic signed [15:0] a, logic signed [15:0] b,
                                      longint frac);
    return ((longint'(FracOne) - frac) * longint'(a) + frac * longint'(b)) / FracOne;
  endfunction

  // Computes the output frame for one input frame and advances the flanger state.
  task automatic flange_frame(input frame_t stim, output frame_t res);
    longint whole;
    longint frac;
    int     tap_a;
    int     tap_b;
    whole = 0;
    frac = 0;
    // A negative offset reads at offset zero with no blend.
    if (sweep_ofs > 0) begin
      whole = sweep_ofs >>> FracBits;
      frac = sweep_ofs & longint'(FracOne - 1);
    end
    tap_a = int'((longint'(wr_pos) + whole) % DEPTH);
    tap_b = (tap_a + 1) % DEPTH;
    res.left = clip16(longint'(stim.left) + mix_taps(dly_left[tap_a], dly_left[tap_b], frac));
    res.right = clip16(longint'(stim.right) +
                       mix_taps(dly_right[tap_a], dly_right[tap_b], frac));
    // The new frame goes in only after both taps are read.
    dly_left[wr_pos] = stim.left;
    dly_right[wr_pos] = stim.right;
    wr_pos = (wr_pos + 1) % DEPTH;
    if (sweep_down) begin
      sweep_ofs -= longint'(sweep_step);
    end else begin
      sweep_ofs += longint'(sweep_step);
    end
    if (sweep_ofs < 0 || sweep_ofs > longint'(DEPTH) * FracOne) begin
      sweep_down = !sweep_down;
    end
  endtask

  // Random sample with extra weight on full scale and small values.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one frame, waits for the transaction and records the expected output.
  task automatic send_frame(input frame_t stim, input bit typed, input frame_t typed_res);
    frame_t res;
    s_tdata <= stim;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    flange_frame(stim, res);
    frames_due.push_back(typed ? typed_res : res);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Waits until every output has arrived and the pipeline is empty.
  task automatic drain_frames();
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the sweep step while the block is idle.
  task automatic retune(input logic [15:0] step);
    drain_frames();
    cfg_we <= 1'b1;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we <= 1'b0;
    sweep_step = step;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_frame({pick_sample(), pick_sample()}, 1'b0, '0);
    end
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest expected frame.
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (frames_due.size() == 0) begin
        $display("%0t unexpected output: expected none, got left %0d right %0d",
                 $time, got.left, got.right);
        faults++;
      end else begin
        want = frames_due.pop_front();
        if (got.left !== want.left) begin
          $display("%0t left_out: expected %0d, got %0d", $time, want.left, got.left);
          faults++;
        end
        if (got.right !== want.right) begin
          $display("%0t right_out: expected %0d, got %0d", $time, want.right, got.right);
          faults++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    foreach (dly_left[k]) begin
      dly_left[k] = '0;
      dly_right[k] = '0;
    end
    // The store reads as zero after reset, so each output equals its input here.
    probes[0]  = '{'{16'h0000, 16'h0000}, '{16'h0000, 16'h0000}};
    probes[1]  = '{'{16'h8000, 16'h7FFF}, '{16'h8000, 16'h7FFF}};
    probes[2]  = '{'{16'h7FFF, 16'h8000}, '{16'h7FFF, 16'h8000}};
    probes[3]  = '{'{16'h0001, 16'hFFFF}, '{16'h0001, 16'hFFFF}};
    probes[4]  = '{'{16'hFFFF, 16'h0001}, '{16'hFFFF, 16'h0001}};
    probes[5]  = '{'{16'hAAAA, 16'h5555}, '{16'hAAAA, 16'h5555}};
    probes[6]  = '{'{16'h5555, 16'hAAAA}, '{16'h5555, 16'hAAAA}};
    probes[7]  = '{'{16'h7FFF, 16'h7FFF}, '{16'h7FFF, 16'h7FFF}};
    probes[8]  = '{'{16'h8000, 16'h8000}, '{16'h8000, 16'h8000}};
    probes[9]  = '{'{16'hFFFF, 16'h0000}, '{16'hFFFF, 16'h0000}};
    probes[10] = '{'{16'hFF00, 16'h0100}, '{16'hFF00, 16'h0100}};
    probes[11] = '{'{16'h1234, 16'hEDCB}, '{16'h1234, 16'hEDCB}};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames with the reset sweep step.
    for (int i = 0; i < 12; i++) begin
      send_frame(probes[i].stim, 1'b1, probes[i].res);
    end

    // Largest step: the offset runs past the depth and then below zero.
    retune(16'hFFFF);
    for (int i = 0; i < 560; i++) begin
      if (i == 100) hold_request = 1'b1;
      if (i == 300) begin
        sender_idle = 1'b0;
        sink_idle = 1'b0;
      end
      if (i == 380) begin
        sender_idle = 1'b1;
        sink_idle = 1'b1;
      end
      send_frame({pick_sample(), pick_sample()}, 1'b0, '0);
    end

    // Frozen sweep, then the smallest step.
    retune(16'd0);
    send_random(40);
    retune(16'd1);
    send_random(40);

    // Step changes in the middle of a sweep.
    repeat (4) begin
      retune(16'($urandom_range(0, 65535)));
      send_random(40);
    end

    // Closing stretch at the reset step with no idling on either side.
    sender_idle = 1'b0;
    sink_idle = 1'b0;
    retune(StepReset);
    send_random(50);

    drain_frames();
    repeat (20) @(posedge clk);
    if (faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
